FILE: sv/assert_macros.svh
// Assertion macros used by the divider sequencer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold whenever the antecedent is seen, same cycle.
`define ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Property that must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

FILE: sv/udiv_pkg.sv
// Shared constants and types of the unsigned restoring divider.
package udiv_pkg;

    localparam int FIELD_W = 64;
    localparam int DATA_W  = 64;
    localparam int CNT_W   = $clog2(DATA_W);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic step;
        logic store;
    } cmd_t;

    typedef struct packed {
        logic dz;
        logic last;
    } sts_t;

endpackage

FILE: sv/udiv_ctrl.sv
// Sequencer of the divider: load, iterate, hand the result to the output register.
`include "assert_macros.svh"

module udiv_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_axis_tvalid,
    output logic            s_axis_tready,
    output logic            m_axis_tvalid,
    input  logic            m_axis_tready,
    input  udiv_pkg::sts_t  sts,
    output udiv_pkg::cmd_t  cmd
);

    udiv_pkg::state_t state_reg, state_next;
    logic             m_valid_reg, m_valid_next;
    logic             slot_free;

    assign slot_free = !m_valid_reg || m_axis_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= udiv_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            udiv_pkg::ST_IDLE: begin
                if (s_axis_tvalid) state_next = udiv_pkg::ST_CALC;
            end
            udiv_pkg::ST_CALC: begin
                if (sts.dz || sts.last) state_next = udiv_pkg::ST_DONE;
            end
            udiv_pkg::ST_DONE: begin
                if (slot_free) state_next = udiv_pkg::ST_IDLE;
            end
            default: state_next = udiv_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_axis_tready = 1'b0;
        cmd           = '0;
        unique case (state_reg)
            udiv_pkg::ST_IDLE: begin
                s_axis_tready = 1'b1;
                cmd.load      = s_axis_tvalid;
            end
            udiv_pkg::ST_CALC: begin
                // A zero divisor skips the iterations entirely.
                cmd.step = !sts.dz;
            end
            udiv_pkg::ST_DONE: begin
                cmd.store = slot_free;
            end
            default: ;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.store) begin
            m_valid_next = 1'b1;
        end else if (m_axis_tready) begin
            m_valid_next = 1'b0;
        end
    end

    assign m_axis_tvalid = m_valid_reg;

    `ASSERT_NEXT(a_load_to_calc, aclk, aresetn, s_axis_tvalid && s_axis_tready,
        state_reg == udiv_pkg::ST_CALC)
    `ASSERT_NEXT(a_finish_to_done, aclk, aresetn,
        state_reg == udiv_pkg::ST_CALC && (sts.dz || sts.last),
        state_reg == udiv_pkg::ST_DONE)
    `ASSERT_SAME(a_result_from_done, aclk, aresetn, $rose(m_valid_reg),
        $past(state_reg) == udiv_pkg::ST_DONE)

endmodule

FILE: sv/udiv_dpath.sv
// Working registers, shared subtractor and result register of the divider.
module udiv_dpath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  udiv_pkg::cmd_t                cmd,
    output udiv_pkg::sts_t                sts,
    input  logic [udiv_pkg::FIELD_W-1:0]  dividend,
    input  logic [udiv_pkg::FIELD_W-1:0]  divisor,
    output logic [udiv_pkg::FIELD_W-1:0]  quotient,
    output logic [udiv_pkg::FIELD_W-1:0]  remainder,
    output logic                          divide_by_zero
);

    localparam int W = udiv_pkg::DATA_W;

    logic [W-1:0]                rem_reg, rem_next;
    logic [W-1:0]                quo_reg, quo_next;
    logic [W-1:0]                dvd_reg, dvd_next;
    logic [W-1:0]                den_reg, den_next;
    logic [udiv_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    logic                        dz_reg, dz_next;
    logic [W-1:0]                q_out_reg;
    logic [W-1:0]                r_out_reg;
    logic                        dz_out_reg;
    logic [W-1:0]                shifted;
    logic [W:0]                  diff;
    logic                        take;

    // The partial remainder keeps its top bit as a carry into the compare.
    assign shifted = {rem_reg[W-2:0], dvd_reg[W-1]};
    assign diff    = {rem_reg[W-1], shifted} - {1'b0, den_reg};
    assign take    = !diff[W];

    always_comb begin
        rem_next = rem_reg;
        quo_next = quo_reg;
        dvd_next = dvd_reg;
        den_next = den_reg;
        cnt_next = cnt_reg;
        dz_next  = dz_reg;
        if (cmd.load) begin
            rem_next = '0;
            quo_next = '0;
            dvd_next = dividend[W-1:0];
            den_next = divisor[W-1:0];
            cnt_next = '0;
            dz_next  = (divisor[W-1:0] == '0);
        end else if (cmd.step) begin
            rem_next = take ? diff[W-1:0] : shifted;
            quo_next = {quo_reg[W-2:0], take};
            dvd_next = {dvd_reg[W-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rem_reg <= '0;
            quo_reg <= '0;
            dvd_reg <= '0;
            den_reg <= '0;
            cnt_reg <= '0;
            dz_reg  <= 1'b0;
        end else begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
            dvd_reg <= dvd_next;
            den_reg <= den_next;
            cnt_reg <= cnt_next;
            dz_reg  <= dz_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.store) begin
            q_out_reg  <= dz_reg ? '1 : quo_reg;
            r_out_reg  <= dz_reg ? '0 : rem_reg;
            dz_out_reg <= dz_reg;
        end
    end

    assign sts.dz         = dz_reg;
    assign sts.last       = cmd.step && (cnt_reg == udiv_pkg::CNT_W'(W - 1));
    assign quotient       = udiv_pkg::FIELD_W'(q_out_reg);
    assign remainder      = udiv_pkg::FIELD_W'(r_out_reg);
    assign divide_by_zero = dz_out_reg;

endmodule

FILE: sv/unsigned_restoring_divider_top.sv
// Top level of the unsigned restoring divider with its stream ports.
//
// Divides an unsigned 64-bit dividend by a 64-bit divisor and returns the
// quotient and remainder in one output transfer. One request is taken at a
// time. After the accepting edge, one quotient bit is produced per cycle
// through the single shared subtract-and-compare unit, and the DONE state
// then moves the result into the output register. The next request can be
// accepted once that result is in the output register. A zero divisor skips
// the iterations and returns an all-ones quotient, a zero remainder and
// tuser set. The output register lets the next request be accepted while
// the previous result still waits to be taken. A finished division that
// finds the output register still full waits until that result is taken.
module unsigned_restoring_divider_top (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [127:0]  s_axis_tdata,   // dividend [63:0], divisor [127:64]
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [127:0]  m_axis_tdata,   // quotient [63:0], remainder [127:64]
    output logic [0:0]    m_axis_tuser    // divide_by_zero [0]
);

    localparam int FW = udiv_pkg::FIELD_W;

    udiv_pkg::cmd_t cmd;
    udiv_pkg::sts_t sts;
    logic [FW-1:0]  quotient;
    logic [FW-1:0]  remainder;
    logic           divide_by_zero;

    udiv_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .sts           (sts),
        .cmd           (cmd)
    );

    udiv_dpath u_dpath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .sts            (sts),
        .dividend       (s_axis_tdata[FW-1:0]),
        .divisor        (s_axis_tdata[2*FW-1:FW]),
        .quotient       (quotient),
        .remainder      (remainder),
        .divide_by_zero (divide_by_zero)
    );

    assign m_axis_tdata = {remainder, quotient};
    assign m_axis_tuser = divide_by_zero;

endmodule

FILE: tb/unsigned_restoring_divider_top_tb.sv
// Self-checking testbench of the unsigned restoring divider with random stream stalls.
module unsigned_restoring_divider_top_tb;

    localparam int NO_TRANSFER_LIMIT = 5000;
    localparam int DRAIN_CYCLES      = 100;

    class divide_scoreboard;
        typedef struct {
            logic [udiv_pkg::FIELD_W-1:0] quotient;
            logic [udiv_pkg::FIELD_W-1:0] remainder;
            logic                         div_by_zero;
        } div_result_t;

        div_result_t expected_q[$];
        int          errors;

        function new();
            errors = 0;
        endfunction

        // Shift-and-subtract, one quotient bit per step from the top down. The bit
        // shifted out of the partial remainder forces a subtract for large divisors.
        function div_result_t divide(input logic [udiv_pkg::FIELD_W-1:0] dividend,
                                     input logic [udiv_pkg::FIELD_W-1:0] divisor);
            div_result_t                  r;
            logic [udiv_pkg::DATA_W-1:0]  num;
            logic [udiv_pkg::DATA_W-1:0]  den;
            logic [udiv_pkg::DATA_W-1:0]  part;
            logic [udiv_pkg::DATA_W-1:0]  quo;
            logic                         carry;
            num = dividend[udiv_pkg::DATA_W-1:0];
            den = divisor[udiv_pkg::DATA_W-1:0];
            r.quotient    = '0;
            r.remainder   = '0;
            r.div_by_zero = 1'b0;
            if (den == '0) begin
                r.quotient[udiv_pkg::DATA_W-1:0] = '1;
                r.div_by_zero                    = 1'b1;
                return r;
            end
            part = '0;
            quo  = '0;
            for (int i = 0; i < udiv_pkg::DATA_W; i++) begin
                carry = part[udiv_pkg::DATA_W-1];
                part  = {part[udiv_pkg::DATA_W-2:0], num[udiv_pkg::DATA_W-1]};
                num   = num << 1;
                quo   = quo << 1;
                if (carry || part >= den) begin
                    part   = part - den;
                    quo[0] = 1'b1;
                end
            end
            r.quotient[udiv_pkg::DATA_W-1:0]  = quo;
            r.remainder[udiv_pkg::DATA_W-1:0] = part;
            return r;
        endfunction

        function void note_request(input logic [udiv_pkg::FIELD_W-1:0] dividend,
                                   input logic [udiv_pkg::FIELD_W-1:0] divisor);
            expected_q.push_back(divide(dividend, divisor));
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        task report_mismatch(input string what, input logic [udiv_pkg::FIELD_W-1:0] got,
                             input logic [udiv_pkg::FIELD_W-1:0] want);
            errors++;
            $display("%0t: %s mismatch: got %h, expected %h",
                     $realtime, what, got, want);
        endtask

        task check_result(input logic [2*udiv_pkg::FIELD_W-1:0] data,
                          input logic [0:0] user);
            div_result_t want;
            if (expected_q.size() == 0) begin
                report_mismatch("unexpected result", data[udiv_pkg::FIELD_W-1:0], '0);
                return;
            end
            want = expected_q.pop_front();
            if (data[udiv_pkg::FIELD_W-1:0] !== want.quotient)
                report_mismatch("quotient", data[udiv_pkg::FIELD_W-1:0], want.quotient);
            if (data[2*udiv_pkg::FIELD_W-1:udiv_pkg::FIELD_W] !== want.remainder)
                report_mismatch("remainder", data[2*udiv_pkg::FIELD_W-1:udiv_pkg::FIELD_W],
                                want.remainder);
            if (user[0] !== want.div_by_zero)
                report_mismatch("divide-by-zero flag", udiv_pkg::FIELD_W'(user[0]),
                                udiv_pkg::FIELD_W'(want.div_by_zero));
        endtask
    endclass

    logic                              aclk          = 1'b0;
    logic                              aresetn       = 1'b0;
    logic                              s_axis_tvalid = 1'b0;
    logic                              s_axis_tready;
    logic [2*udiv_pkg::FIELD_W-1:0]    s_axis_tdata  = '0;  // dividend [63:0], divisor [127:64]
    logic                              m_axis_tvalid;
    logic                              m_axis_tready = 1'b0;
    logic [2*udiv_pkg::FIELD_W-1:0]    m_axis_tdata;        // quotient [63:0], remainder [127:64]
    logic [0:0]                        m_axis_tuser;        // divide_by_zero [0]

    divide_scoreboard div_sb = new();
    int               src_idle_pct = 0;
    int               dst_idle_pct = 0;
    int               no_transfer_cycles = 0;

    unsigned_restoring_divider_top uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Called and returning at a rising edge; tvalid stays high between back-to-back
    // requests so that it never gets two assignments in one step.
    task automatic send_request(input logic [udiv_pkg::FIELD_W-1:0] dividend,
                                input logic [udiv_pkg::FIELD_W-1:0] divisor);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {divisor, dividend};
        do @(posedge aclk); while (!s_axis_tready);
        div_sb.note_request(dividend, divisor);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (div_sb.pending() != 0) @(posedge aclk);
    endtask

    function automatic logic [udiv_pkg::FIELD_W-1:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    // Random values of random magnitude, so quotients of every length show up.
    function automatic logic [udiv_pkg::FIELD_W-1:0] rand_operand();
        case ($urandom_range(3))
            0:       return rand_word();
            1:       return rand_word() >> $urandom_range(udiv_pkg::FIELD_W - 1);
            2:       return rand_word() | {1'b1, {(udiv_pkg::FIELD_W - 1){1'b0}}};
            default: return rand_word() >> $urandom_range(udiv_pkg::FIELD_W - 1,
                                                          udiv_pkg::FIELD_W - 8);
        endcase
    endfunction

    task automatic random_phase(input int count);
        logic [udiv_pkg::FIELD_W-1:0] dividend;
        logic [udiv_pkg::FIELD_W-1:0] divisor;
        for (int i = 0; i < count; i++) begin
            dividend = rand_operand();
            case ($urandom_range(31))
                0:       divisor = '0;
                1:       divisor = dividend;
                2:       divisor = dividend + 1;
                default: divisor = rand_operand();
            endcase
            send_request(dividend, divisor);
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready)
                div_sb.check_result(m_axis_tdata, m_axis_tuser);
            m_axis_tready <= ($urandom_range(99) >= dst_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                no_transfer_cycles = 0;
            else
                no_transfer_cycles++;
            if (no_transfer_cycles >= NO_TRANSFER_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    localparam logic [udiv_pkg::FIELD_W-1:0] ALL_ONES = '1;
    localparam logic [udiv_pkg::FIELD_W-1:0] TOP_BIT  =
        {1'b1, {(udiv_pkg::FIELD_W - 1){1'b0}}};

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        src_idle_pct = 29;
        dst_idle_pct = 60;
        send_request('0, '0);
        send_request(ALL_ONES, '0);
        send_request(64'h0123_4567_89ab_cdef, '0);
        send_request(ALL_ONES, 64'd1);
        send_request(ALL_ONES, ALL_ONES);
        send_request('0, ALL_ONES);
        send_request(64'd1, ALL_ONES);
        send_request(ALL_ONES - 1, ALL_ONES);
        // Divisors above half scale make the partial remainder overflow its width.
        send_request(ALL_ONES, TOP_BIT + 1);
        send_request(ALL_ONES, TOP_BIT);
        send_request(TOP_BIT, TOP_BIT + 1);
        send_request(ALL_ONES, ALL_ONES - 1);
        send_request(TOP_BIT, 64'd2);
        send_request(64'd12345, 64'd7);
        send_request(64'd7, 64'd12345);
        send_request(64'd1000, 64'd1000);
        send_request(64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555);
        send_request(64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa);
        send_request(ALL_ONES, 64'h0000_0001_0000_0000);
        // The sender holds off here until the divider has returned everything.
        drain_results();
        @(posedge aclk);

        random_phase(600);
        src_idle_pct = 60;
        dst_idle_pct = 29;
        random_phase(600);
        src_idle_pct = 0;
        dst_idle_pct = 0;
        random_phase(600);

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (div_sb.errors == 0 && div_sb.pending() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule

FILE: files.f
+incdir+sv
sv/udiv_pkg.sv
sv/udiv_ctrl.sv
sv/udiv_dpath.sv
sv/unsigned_restoring_divider_top.sv
tb/unsigned_restoring_divider_top_tb.sv
